// ===== hw/rtl/vsb_pkg.sv =====
// vsb_pkg: types and constants for the virtual sensor EMA blend block.
// No dependencies; used by the channel interfaces and the top level.

package vsb_pkg;

   localparam int CHANNELS      = 4;
   localparam int CHAN_BITS     = 2;
   localparam int READING_BITS  = 24;
   localparam int COUNT_BITS    = 3;
   localparam int SETUP_BITS    = 34;
   localparam int GAIN_BITS     = 24;
   localparam int OFFSET_BITS   = 32;
   localparam int RESULT_BITS   = 32;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 34;
   localparam int EMA_BITS      = 40;
   localparam int SEED_BITS     = 41;
   localparam int SUM_BITS      = 48;
   localparam int TERM_BITS     = 46;
   localparam int ACC_BITS      = 60;
   localparam int WIDE_BITS     = 50;
   localparam int MPL_BITS      = 24;
   localparam int STEP_BITS     = 5;
   localparam int REM_BITS      = 10;

   // setup register fields
   localparam int ALPHA_LSB  = 0;
   localparam int COEFF_LSB  = 16;
   localparam int POWER_BIT  = 32;
   localparam int CONST_BIT  = 33;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COUNT   = 3'd0,
      CSR_SETUP_0 = 3'd1,
      CSR_SETUP_1 = 3'd2,
      CSR_SETUP_2 = 3'd3,
      CSR_SETUP_3 = 3'd4,
      CSR_GAIN    = 3'd5,
      CSR_OFFSET  = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP,
      ST_MUL_A,
      ST_MUL_W,
      ST_EMA,
      ST_MUL_C,
      ST_TERM,
      ST_SUM,
      ST_FIN,
      ST_BYP_MUL,
      ST_BYP_OUT
   } state_type;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 3'd4;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE   = 3'd1;
   localparam logic signed [GAIN_BITS-1:0] GAIN_RESET = 24'sd65536;

   localparam logic [READING_BITS-1:0] CONST_READING = 24'd1000;
   localparam logic [REM_BITS:0]       DIVISOR       = 11'd1000;
   localparam logic [16:0]             ALPHA_ONE     = 17'd32768;

   localparam logic [STEP_BITS-1:0] DIV_LAST   = 5'd23;
   localparam logic [STEP_BITS-1:0] MUL17_LAST = 5'd16;
   localparam logic [STEP_BITS-1:0] MUL16_LAST = 5'd15;
   localparam logic [STEP_BITS-1:0] MUL24_LAST = 5'd23;

   // rounding increments: half, and half minus one for negative values (T16_NEG: truncation)
   localparam logic signed [ACC_BITS-1:0]  R15_POS = 60'sd16384;
   localparam logic signed [ACC_BITS-1:0]  R15_NEG = 60'sd16383;
   localparam logic signed [ACC_BITS-1:0]  R12_POS = 60'sd2048;
   localparam logic signed [ACC_BITS-1:0]  R12_NEG = 60'sd2047;
   localparam logic signed [WIDE_BITS-1:0] R16_POS = 50'sd32768;
   localparam logic signed [WIDE_BITS-1:0] R16_NEG = 50'sd32767;
   localparam logic signed [ACC_BITS-1:0]  T16_NEG = 60'sd65535;
   localparam logic signed [ACC_BITS-1:0]  ACC_ZERO = 60'sd0;

   localparam logic signed [ACC_BITS-1:0]  EMA_MAX_A = 60'sd549755813887;
   localparam logic signed [ACC_BITS-1:0]  EMA_MIN_A = -60'sd549755813888;
   localparam logic signed [WIDE_BITS-1:0] SUM_MAX_W = 50'sd140737488355327;
   localparam logic signed [WIDE_BITS-1:0] SUM_MIN_W = -50'sd140737488355328;
   localparam logic signed [WIDE_BITS-1:0] I32_MAX_W = 50'sd2147483647;
   localparam logic signed [WIDE_BITS-1:0] I32_MIN_W = -50'sd2147483648;
   localparam logic signed [ACC_BITS-1:0]  I32_MAX_A = 60'sd2147483647;
   localparam logic signed [ACC_BITS-1:0]  I32_MIN_A = -60'sd2147483648;

endpackage

// ===== hw/rtl/vsb_if.sv =====
// vsb_if: valid/ready channel interfaces for readings and results.
// Depends on vsb_pkg for field widths.

interface vsb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [vsb_pkg::CHAN_BITS-1:0]        channel;
   logic [vsb_pkg::READING_BITS-1:0]     reading;

   modport source (output valid, output channel, output reading, input ready);
   modport sink   (input valid, input channel, input reading, output ready);
endinterface

interface vsb_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [vsb_pkg::RESULT_BITS-1:0] result_value;
   logic                                 is_bypass;

   modport source (output valid, output result_value, output is_bypass, input ready);
   modport sink   (input valid, input result_value, input is_bypass, output ready);
endinterface

// ===== hw/rtl/virtual_sensor_ema_blend.sv =====
// virtual_sensor_ema_blend: per-channel EMA of sensor readings blended into a weighted sum.
// Depends on vsb_pkg and the channel interfaces in vsb_if.sv.
//
// Usage: req_bus carries one beat per reading (channel, reading); rsp_bus carries one
// beat per result (result_value, is_bypass). The user must write registers on the csr_
// port only while the block is idle; the block itself does not enforce this. A beat is
// taken only in the idle state, one at a time. Blend beat: a restoring divider by 1000
// producing 24 quotient bits (skipped for power channels), then two 17-bit and one
// 16-bit signed shift-add multiplications, one multiplier bit per cycle, plus five
// round/accumulate steps. Bypass beat: a 24-bit shift-add multiplication and one
// truncation step. Beats that are ignored (channel beyond the count, or not channel 0
// in bypass) leave ready high.
// A finished result sits in the output register; the next reading is accepted while
// it waits. If the receiver still stalls when the following result is due, the block
// holds in its final step until the output register is free.
// Reset (synchronous, active high) clears the averages, the sum, the registers to
// their defaults and any result in flight.

module virtual_sensor_ema_blend (
   input  logic                                  clock,
   input  logic                                  reset,
   vsb_req_if.sink                               req_bus,
   vsb_rsp_if.source                             rsp_bus,
   input  logic                                  csr_we,
   input  logic [vsb_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [vsb_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   // configuration
   logic [vsb_pkg::COUNT_BITS-1:0]           count_ff;
   logic [vsb_pkg::SETUP_BITS-1:0]           setup_ff [vsb_pkg::CHANNELS];
   logic signed [vsb_pkg::GAIN_BITS-1:0]     gain_ff;
   logic signed [vsb_pkg::OFFSET_BITS-1:0]   offset_ff;

   // state and datapath
   vsb_pkg::state_type                       state_ff, state_in;
   logic [vsb_pkg::CHAN_BITS-1:0]            chan_ff, chan_in;
   logic                                     last_ff, last_in;
   logic [vsb_pkg::READING_BITS-1:0]         t_ff, t_in;
   logic [vsb_pkg::REM_BITS-1:0]             rem_ff, rem_in;
   logic signed [vsb_pkg::ACC_BITS-1:0]      acc_ff, acc_in;
   logic signed [vsb_pkg::ACC_BITS-1:0]      mcand_ff, mcand_in;
   logic [vsb_pkg::MPL_BITS-1:0]             mplier_ff, mplier_in;
   logic [vsb_pkg::STEP_BITS-1:0]            step_ff, step_in;
   logic signed [vsb_pkg::SEED_BITS-1:0]     seed_ff, seed_in;
   logic signed [vsb_pkg::TERM_BITS-1:0]     term_ff, term_in;
   logic signed [vsb_pkg::SUM_BITS-1:0]      sum_ff, sum_in;
   logic signed [vsb_pkg::EMA_BITS-1:0]      ema_ff [vsb_pkg::CHANNELS];
   logic                                     ema_we;
   logic signed [vsb_pkg::EMA_BITS-1:0]      ema_sat;

   logic                                     rsp_valid_ff, rsp_valid_in;
   logic signed [vsb_pkg::RESULT_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                                     rsp_byp_ff, rsp_byp_in;

   // combinational helpers
   logic                                     accept;
   logic                                     out_free;
   logic                                     bypass_mode;
   logic [vsb_pkg::COUNT_BITS-1:0]           eff_count;
   logic [vsb_pkg::COUNT_BITS-1:0]           chan_ext;
   logic [vsb_pkg::SETUP_BITS-1:0]           new_setup;
   logic [vsb_pkg::SETUP_BITS-1:0]           cur_setup;
   logic [15:0]                              alpha;
   logic [15:0]                              coeff;
   logic [16:0]                              weight;
   logic signed [vsb_pkg::ACC_BITS-1:0]      mul_add;
   logic signed [vsb_pkg::ACC_BITS-1:0]      mul_acc;
   logic                                     mul_done;
   logic [vsb_pkg::REM_BITS:0]               div_trial;
   logic [vsb_pkg::REM_BITS:0]               div_diff;
   logic                                     div_ge;
   logic signed [vsb_pkg::EMA_BITS-1:0]      ema_cur;
   logic signed [vsb_pkg::ACC_BITS-1:0]      ema_rnd;
   logic signed [vsb_pkg::ACC_BITS-1:0]      term_rnd;
   logic signed [vsb_pkg::WIDE_BITS-1:0]     sum_wide;
   logic signed [vsb_pkg::WIDE_BITS-1:0]     sum_add;
   logic signed [vsb_pkg::WIDE_BITS-1:0]     fin_rnd;
   logic signed [vsb_pkg::ACC_BITS-1:0]      byp_sh;

   assign accept      = req_bus.valid && req_bus.ready;
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign bypass_mode = (setup_ff[0][31:0] == 32'd0) && !setup_ff[0][vsb_pkg::CONST_BIT];
   assign chan_ext    = {1'b0, req_bus.channel};
   assign new_setup   = setup_ff[req_bus.channel];
   assign cur_setup   = setup_ff[chan_ff];
   assign alpha       = cur_setup[vsb_pkg::ALPHA_LSB +: 16];
   assign coeff       = cur_setup[vsb_pkg::COEFF_LSB +: 16];
   assign weight      = vsb_pkg::ALPHA_ONE - {1'b0, alpha};
   assign ema_cur     = ema_ff[chan_ff];

   always_comb begin
      if (count_ff == '0) begin
         eff_count = vsb_pkg::COUNT_ONE;
      end else if (count_ff > vsb_pkg::COUNT_MAX) begin
         eff_count = vsb_pkg::COUNT_MAX;
      end else begin
         eff_count = count_ff;
      end
   end

   // shift-add multiplier step; the final multiplier bit carries negative weight
   assign mul_done = (step_ff == '0);
   assign mul_add  = mplier_ff[0] ? mcand_ff : vsb_pkg::ACC_ZERO;
   assign mul_acc  = mul_done ? (acc_ff - mul_add) : (acc_ff + mul_add);

   // restoring divide by 1000, one quotient bit per cycle
   assign div_trial = {rem_ff, t_ff[vsb_pkg::READING_BITS-1]};
   assign div_diff  = div_trial - vsb_pkg::DIVISOR;
   assign div_ge    = (div_trial >= vsb_pkg::DIVISOR);

   // rounding, half away from zero
   assign ema_rnd  = (acc_ff + (acc_ff[vsb_pkg::ACC_BITS-1] ? vsb_pkg::R15_NEG
                                                            : vsb_pkg::R15_POS)) >>> 15;
   assign term_rnd = (acc_ff + (acc_ff[vsb_pkg::ACC_BITS-1] ? vsb_pkg::R12_NEG
                                                            : vsb_pkg::R12_POS)) >>> 12;
   assign sum_wide = {{(vsb_pkg::WIDE_BITS-vsb_pkg::SUM_BITS){sum_ff[vsb_pkg::SUM_BITS-1]}},
                      sum_ff};
   assign sum_add  = sum_wide
                   + {{(vsb_pkg::WIDE_BITS-vsb_pkg::TERM_BITS){term_ff[vsb_pkg::TERM_BITS-1]}},
                      term_ff};
   assign fin_rnd  = (sum_wide + (sum_ff[vsb_pkg::SUM_BITS-1] ? vsb_pkg::R16_NEG
                                                              : vsb_pkg::R16_POS)) >>> 16;
   // truncation toward zero
   assign byp_sh   = (acc_ff + (acc_ff[vsb_pkg::ACC_BITS-1] ? vsb_pkg::T16_NEG
                                                            : vsb_pkg::ACC_ZERO)) >>> 16;

   always_comb begin
      if (ema_rnd > vsb_pkg::EMA_MAX_A) begin
         ema_sat = vsb_pkg::EMA_MAX_A[vsb_pkg::EMA_BITS-1:0];
      end else if (ema_rnd < vsb_pkg::EMA_MIN_A) begin
         ema_sat = vsb_pkg::EMA_MIN_A[vsb_pkg::EMA_BITS-1:0];
      end else begin
         ema_sat = ema_rnd[vsb_pkg::EMA_BITS-1:0];
      end
   end

   assign req_bus.ready        = (state_ff == vsb_pkg::ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_value = rsp_value_ff;
   assign rsp_bus.is_bypass    = rsp_byp_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      last_in      = last_ff;
      t_in         = t_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      step_in      = step_ff;
      seed_in      = seed_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      ema_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_byp_in   = rsp_byp_ff;

      unique case (state_ff)
         vsb_pkg::ST_IDLE: begin
            if (accept) begin
               chan_in = req_bus.channel;
               t_in    = req_bus.reading;
               last_in = ((chan_ext + vsb_pkg::COUNT_ONE) == eff_count);
               if (bypass_mode) begin
                  if (req_bus.channel == '0) begin
                     acc_in    = {{(vsb_pkg::ACC_BITS-vsb_pkg::OFFSET_BITS-8)
                                   {offset_ff[vsb_pkg::OFFSET_BITS-1]}}, offset_ff, 8'd0};
                     mcand_in  = {{(vsb_pkg::ACC_BITS-vsb_pkg::READING_BITS){1'b0}},
                                  req_bus.reading};
                     mplier_in = gain_ff;
                     step_in   = vsb_pkg::MUL24_LAST;
                     state_in  = vsb_pkg::ST_BYP_MUL;
                  end
               end else if (chan_ext < eff_count) begin
                  if (new_setup[vsb_pkg::CONST_BIT]) begin
                     t_in = vsb_pkg::CONST_READING;
                  end
                  if (!new_setup[vsb_pkg::POWER_BIT]) begin
                     rem_in   = '0;
                     step_in  = vsb_pkg::DIV_LAST;
                     state_in = vsb_pkg::ST_DIV;
                  end else begin
                     state_in = vsb_pkg::ST_PREP;
                  end
               end
            end
         end
         vsb_pkg::ST_DIV: begin
            rem_in  = div_ge ? div_diff[vsb_pkg::REM_BITS-1:0]
                             : div_trial[vsb_pkg::REM_BITS-1:0];
            t_in    = {t_ff[vsb_pkg::READING_BITS-2:0], div_ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = vsb_pkg::ST_PREP;
            end
         end
         vsb_pkg::ST_PREP: begin
            // a zero average means unseeded
            if (ema_cur == '0) begin
               seed_in = {1'b0, t_ff, 16'd0};
            end else begin
               seed_in = {ema_cur[vsb_pkg::EMA_BITS-1], ema_cur};
            end
            acc_in    = vsb_pkg::ACC_ZERO;
            mcand_in  = {{(vsb_pkg::ACC_BITS-vsb_pkg::READING_BITS-16){1'b0}}, t_ff, 16'd0};
            mplier_in = {8'd0, alpha};
            step_in   = vsb_pkg::MUL17_LAST;
            state_in  = vsb_pkg::ST_MUL_A;
         end
         vsb_pkg::ST_MUL_A: begin
            acc_in    = mul_acc;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (mul_done) begin
               mcand_in  = {{(vsb_pkg::ACC_BITS-vsb_pkg::SEED_BITS)
                             {seed_ff[vsb_pkg::SEED_BITS-1]}}, seed_ff};
               mplier_in = {{7{weight[16]}}, weight};
               step_in   = vsb_pkg::MUL17_LAST;
               state_in  = vsb_pkg::ST_MUL_W;
            end
         end
         vsb_pkg::ST_MUL_W: begin
            acc_in    = mul_acc;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (mul_done) begin
               state_in = vsb_pkg::ST_EMA;
            end
         end
         vsb_pkg::ST_EMA: begin
            ema_we    = 1'b1;
            acc_in    = vsb_pkg::ACC_ZERO;
            mcand_in  = {{(vsb_pkg::ACC_BITS-vsb_pkg::EMA_BITS)
                          {ema_sat[vsb_pkg::EMA_BITS-1]}}, ema_sat};
            mplier_in = {{8{coeff[15]}}, coeff};
            step_in   = vsb_pkg::MUL16_LAST;
            state_in  = vsb_pkg::ST_MUL_C;
         end
         vsb_pkg::ST_MUL_C: begin
            acc_in    = mul_acc;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (mul_done) begin
               state_in = vsb_pkg::ST_TERM;
            end
         end
         vsb_pkg::ST_TERM: begin
            term_in  = term_rnd[vsb_pkg::TERM_BITS-1:0];
            state_in = vsb_pkg::ST_SUM;
         end
         vsb_pkg::ST_SUM: begin
            if (sum_add > vsb_pkg::SUM_MAX_W) begin
               sum_in = vsb_pkg::SUM_MAX_W[vsb_pkg::SUM_BITS-1:0];
            end else if (sum_add < vsb_pkg::SUM_MIN_W) begin
               sum_in = vsb_pkg::SUM_MIN_W[vsb_pkg::SUM_BITS-1:0];
            end else begin
               sum_in = sum_add[vsb_pkg::SUM_BITS-1:0];
            end
            state_in = last_ff ? vsb_pkg::ST_FIN : vsb_pkg::ST_IDLE;
         end
         vsb_pkg::ST_FIN: begin
            if (out_free) begin
               if (fin_rnd > vsb_pkg::I32_MAX_W) begin
                  rsp_value_in = vsb_pkg::I32_MAX_W[vsb_pkg::RESULT_BITS-1:0];
               end else if (fin_rnd < vsb_pkg::I32_MIN_W) begin
                  rsp_value_in = vsb_pkg::I32_MIN_W[vsb_pkg::RESULT_BITS-1:0];
               end else begin
                  rsp_value_in = fin_rnd[vsb_pkg::RESULT_BITS-1:0];
               end
               rsp_byp_in   = 1'b0;
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               state_in     = vsb_pkg::ST_IDLE;
            end
         end
         vsb_pkg::ST_BYP_MUL: begin
            acc_in    = mul_acc;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (mul_done) begin
               state_in = vsb_pkg::ST_BYP_OUT;
            end
         end
         vsb_pkg::ST_BYP_OUT: begin
            if (out_free) begin
               if (byp_sh > vsb_pkg::I32_MAX_A) begin
                  rsp_value_in = vsb_pkg::I32_MAX_A[vsb_pkg::RESULT_BITS-1:0];
               end else if (byp_sh < vsb_pkg::I32_MIN_A) begin
                  rsp_value_in = vsb_pkg::I32_MIN_A[vsb_pkg::RESULT_BITS-1:0];
               end else begin
                  rsp_value_in = byp_sh[vsb_pkg::RESULT_BITS-1:0];
               end
               rsp_byp_in   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = vsb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vsb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vsb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff      <= chan_in;
      last_ff      <= last_in;
      t_ff         <= t_in;
      rem_ff       <= rem_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      step_ff      <= step_in;
      seed_ff      <= seed_in;
      term_ff      <= term_in;
      rsp_value_ff <= rsp_value_in;
      rsp_byp_ff   <= rsp_byp_in;
   end

   // channel averages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vsb_pkg::CHANNELS; i++) begin
            ema_ff[i] <= '0;
         end
      end else if (ema_we) begin
         ema_ff[chan_ff] <= ema_sat;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= vsb_pkg::COUNT_RESET;
         for (int i = 0; i < vsb_pkg::CHANNELS; i++) begin
            setup_ff[i] <= '0;
         end
         gain_ff   <= vsb_pkg::GAIN_RESET;
         offset_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            vsb_pkg::CSR_COUNT:   count_ff    <= csr_wdata[vsb_pkg::COUNT_BITS-1:0];
            vsb_pkg::CSR_SETUP_0: setup_ff[0] <= csr_wdata[vsb_pkg::SETUP_BITS-1:0];
            vsb_pkg::CSR_SETUP_1: setup_ff[1] <= csr_wdata[vsb_pkg::SETUP_BITS-1:0];
            vsb_pkg::CSR_SETUP_2: setup_ff[2] <= csr_wdata[vsb_pkg::SETUP_BITS-1:0];
            vsb_pkg::CSR_SETUP_3: setup_ff[3] <= csr_wdata[vsb_pkg::SETUP_BITS-1:0];
            vsb_pkg::CSR_GAIN:    gain_ff     <= csr_wdata[vsb_pkg::GAIN_BITS-1:0];
            vsb_pkg::CSR_OFFSET:  offset_ff   <= csr_wdata[vsb_pkg::OFFSET_BITS-1:0];
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   // the divider only runs for temperature channels
   a_div_not_power: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vsb_pkg::ST_DIV) |-> !cur_setup[vsb_pkg::POWER_BIT])
      else $error("divider running for a power channel");

   // a new result beat only comes from one of the two final steps
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         $past(state_ff == vsb_pkg::ST_FIN || state_ff == vsb_pkg::ST_BYP_OUT))
      else $error("result beat raised outside a final step");

   // a blend result empties the sum
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vsb_pkg::ST_FIN && out_free) |=> (sum_ff == '0))
      else $error("sum not cleared after blend result");

   // bypass multiply only for channel 0 beats
   a_bypass_chan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vsb_pkg::ST_BYP_MUL) |-> (chan_ff == '0))
      else $error("bypass scaling for a channel other than 0");
`endif

endmodule
